// ===== rtl/core/hzr_pkg.sv =====
// ----------------------------------------------------------------------------
// hzr_pkg - shared types, constants and microcode for the zap range generator
// Field widths, register indexes, sequencer step codes and the control ROM.
// ----------------------------------------------------------------------------
package hzr_pkg;

    localparam int unsigned MAX_HARMONICS_DEF = 64;

    localparam int unsigned FREQ_W = 32;   // band edge, Q16.16 Hz
    localparam int unsigned EDGE_W = 33;   // doubled edge / sum of edges
    localparam int unsigned SCL_W  = 40;   // doubled frequency after harmonic scaling
    localparam int unsigned HARM_W = 7;
    localparam int unsigned BIN_W  = 27;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned BPH_W  = 32;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_BINS_PER_HZ     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPECTRUM_POINTS = 2'd1;

    localparam logic [BPH_W-1:0] BINS_PER_HZ_RST = 32'd65536;
    localparam logic [BIN_W-1:0] NPTS_RST        = 27'd1048576;

    typedef logic [2:0] step_t;

    localparam step_t STEP_EDGE_A = 3'd0;  // lower edge frequency
    localparam step_t STEP_MUL_A  = 3'd1;
    localparam step_t STEP_ACC_A  = 3'd2;  // also loads upper edge frequency
    localparam step_t STEP_FOLD_A = 3'd3;  // also multiplies upper edge
    localparam step_t STEP_ACC_B  = 3'd4;
    localparam step_t STEP_FOLD_B = 3'd5;
    localparam step_t STEP_EMIT   = 3'd6;
    localparam step_t STEP_EMPTY  = 3'd7;

    typedef struct packed {
        logic mul;
        logic acc;
        logic fold_s;
        logic fold_e;
    } bin_ctl_t;

    typedef struct packed {
        logic     load_f;
        logic     sel_b;
        bin_ctl_t bin;
        logic     emit;
        logic     empty;
    } uop_t;

    function automatic uop_t ucode(input step_t step);
        uop_t u;
        u = '0;
        unique case (step)
            STEP_EDGE_A: begin
                u.load_f = 1'b1;
            end
            STEP_MUL_A: begin
                u.bin.mul = 1'b1;
            end
            STEP_ACC_A: begin
                u.bin.acc = 1'b1;
                u.load_f  = 1'b1;
                u.sel_b   = 1'b1;
            end
            STEP_FOLD_A: begin
                u.bin.fold_s = 1'b1;
                u.bin.mul    = 1'b1;
            end
            STEP_ACC_B: begin
                u.bin.acc = 1'b1;
            end
            STEP_FOLD_B: begin
                u.bin.fold_e = 1'b1;
            end
            STEP_EMIT: begin
                u.emit = 1'b1;
            end
            STEP_EMPTY: begin
                u.empty = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/hzr_bin_unit.sv =====
// ----------------------------------------------------------------------------
// hzr_bin_unit - frequency to bin converter
// Rounds doubled frequency times bins_per_hz to a bin in two multiply halves,
// then folds about Nyquist and clamps at zero.
// ----------------------------------------------------------------------------
module hzr_bin_unit (
    input  logic                          aclk,
    input  hzr_pkg::bin_ctl_t             ctl,
    input  logic [hzr_pkg::SCL_W-1:0]     freq,
    input  logic [hzr_pkg::BPH_W-1:0]     bins_per_hz,
    input  logic [hzr_pkg::BIN_W-1:0]     npts,
    output logic [hzr_pkg::BIN_W-1:0]     s_bin,
    output logic [hzr_pkg::BIN_W-1:0]     e_bin
);

    logic [55:0] mul_hi;
    logic [56:0] mul_lo;
    logic [56:0] acc_sum;
    logic [55:0] ph_reg;
    logic [40:0] pl_reg;
    logic [39:0] v_reg;
    logic [27:0] np2;
    logic [27:0] fold_diff;
    logic [hzr_pkg::BIN_W-1:0] fold_bin;
    logic [hzr_pkg::BIN_W-1:0] s_reg;
    logic [hzr_pkg::BIN_W-1:0] e_reg;

    // f*B + 2^32 split on the 16-bit halves of B
    assign mul_hi  = {16'b0, freq} * {40'b0, bins_per_hz[31:16]};
    assign mul_lo  = {17'b0, freq} * {41'b0, bins_per_hz[15:0]} + 57'h1_0000_0000;
    assign acc_sum = {1'b0, ph_reg} + {16'b0, pl_reg};

    assign np2       = {npts, 1'b0};
    assign fold_diff = np2 - v_reg[27:0];

    always_comb begin
        if (v_reg <= {13'b0, npts}) begin
            fold_bin = v_reg[26:0];
        end else if (v_reg >= {12'b0, np2}) begin
            fold_bin = '0;                  // folds below zero
        end else begin
            fold_bin = fold_diff[26:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            ph_reg <= mul_hi;
            pl_reg <= mul_lo[56:16];
        end
        if (ctl.acc) begin
            v_reg <= acc_sum[56:17];
        end
        if (ctl.fold_s) begin
            s_reg <= fold_bin;
        end
        if (ctl.fold_e) begin
            e_reg <= fold_bin;
        end
    end

    assign s_bin = s_reg;
    assign e_bin = e_reg;

endmodule

// ===== rtl/core/harmonic_zap_range_generator_top.sv =====
// ----------------------------------------------------------------------------
// harmonic_zap_range_generator_top - harmonic zap range generator
// Expands one zap entry into per-harmonic spectrum bin ranges with a running
// count of zeroed bins, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                                 tuser / tlast
// s_axis    in   band_low, band_high, first_harmonic, last_harmonic  tuser fixed_width
// m_axis    out  bin_start, bin_end, harmonic_number, bins_zeroed    tlast last
// cfg       in   cfg_addr 0 bins_per_hz, 1 spectrum_points           -
//
// For each entry the sequencer runs 7 microcode steps per harmonic (a single
// empty step when no harmonic is in range) through one shared multiplier pair
// and fold stage.
// Reset is synchronous, active low; control and configuration registers return to their defaults.
// A stalled m_axis holds the emit step until the output register frees.
// s_axis_tready is high only while no entry is being expanded.
// ----------------------------------------------------------------------------
module harmonic_zap_range_generator_top #(
    parameter int unsigned MAX_HARMONICS = hzr_pkg::MAX_HARMONICS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // band_low[31:0], band_high[63:32], first_harmonic[70:64], last_harmonic[77:71]
    input  logic [79:0]                       s_axis_tdata,
    // fixed_width[0]
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bin_start[26:0], bin_end[53:27], harmonic_number[60:54], bins_zeroed[92:61]
    output logic [95:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,

    input  logic                              cfg_wr_en,
    input  logic [hzr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [hzr_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int unsigned HCAP = (MAX_HARMONICS > 127) ? 127 : MAX_HARMONICS;
    localparam logic [hzr_pkg::HARM_W-1:0] HCAP_H = hzr_pkg::HARM_W'(HCAP);

    // configuration
    logic [hzr_pkg::BPH_W-1:0]  bph_reg;
    logic [hzr_pkg::BIN_W-1:0]  np_reg;

    // sequencer and entry state
    logic                        busy_reg;
    hzr_pkg::step_t              pc_reg;
    logic [hzr_pkg::HARM_W-1:0]  h_reg;
    logic [hzr_pkg::HARM_W-1:0]  end_h_reg;
    logic [hzr_pkg::EDGE_W-1:0]  base_a_reg;
    logic [hzr_pkg::EDGE_W-1:0]  base_b_reg;
    logic signed [hzr_pkg::EDGE_W-1:0] off_reg;
    logic [hzr_pkg::CNT_W-1:0]   total_reg;
    logic [hzr_pkg::SCL_W-1:0]   freq_reg;

    // output register
    logic                        m_valid_reg;
    logic                        m_last_reg;
    logic [hzr_pkg::BIN_W-1:0]   m_start_reg;
    logic [hzr_pkg::BIN_W-1:0]   m_end_reg;
    logic [hzr_pkg::HARM_W-1:0]  m_harm_reg;
    logic [hzr_pkg::CNT_W-1:0]   m_count_reg;

    hzr_pkg::uop_t               uop;
    logic                        s_accept;
    logic                        out_free;
    logic                        out_load;

    logic [hzr_pkg::FREQ_W-1:0]  in_lo;
    logic [hzr_pkg::FREQ_W-1:0]  in_hi;
    logic [hzr_pkg::HARM_W-1:0]  in_fh;
    logic [hzr_pkg::HARM_W-1:0]  in_lh;
    logic [hzr_pkg::HARM_W-1:0]  fh_adj;
    logic [hzr_pkg::HARM_W-1:0]  lh_adj;
    logic [hzr_pkg::EDGE_W-1:0]  in_sum;
    logic [hzr_pkg::EDGE_W-1:0]  in_diff;

    logic [hzr_pkg::EDGE_W-1:0]  base_sel;
    logic [hzr_pkg::SCL_W-1:0]   scaled;
    logic signed [41:0]          off_ext;
    logic signed [41:0]          f_sum;

    logic [hzr_pkg::BIN_W-1:0]   s_bin;
    logic [hzr_pkg::BIN_W-1:0]   e_bin;
    logic [hzr_pkg::BIN_W-1:0]   lo_bin;
    logic [hzr_pkg::BIN_W-1:0]   hi_bin;
    logic [hzr_pkg::BIN_W-1:0]   span;
    logic [hzr_pkg::CNT_W:0]     tot_wide;
    logic [hzr_pkg::CNT_W-1:0]   tot_sat;
    logic                        last_harm;

    assign uop      = hzr_pkg::ucode(pc_reg);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = busy_reg && (uop.emit || uop.empty) && out_free;

    // entry unpacking
    assign in_lo  = s_axis_tdata[31:0];
    assign in_hi  = s_axis_tdata[63:32];
    assign in_fh  = s_axis_tdata[70:64];
    assign in_lh  = s_axis_tdata[77:71];
    assign fh_adj = (in_fh == '0) ? hzr_pkg::HARM_W'(1) : in_fh;
    assign lh_adj = (in_lh > HCAP_H) ? HCAP_H : in_lh;
    assign in_sum  = {1'b0, in_lo} + {1'b0, in_hi};
    assign in_diff = {1'b0, in_hi} - {1'b0, in_lo};

    // doubled edge frequency: base*h +/- doubled half width (never negative)
    assign base_sel = uop.sel_b ? base_b_reg : base_a_reg;
    assign scaled   = {7'b0, base_sel} * {33'b0, h_reg};
    assign off_ext  = {{9{off_reg[hzr_pkg::EDGE_W-1]}}, off_reg};
    assign f_sum    = $signed({2'b0, scaled}) + (uop.sel_b ? off_ext : -off_ext);

    hzr_bin_unit u_bin (
        .aclk        (aclk),
        .ctl         (uop.bin),
        .freq        (freq_reg),
        .bins_per_hz (bph_reg),
        .npts        (np_reg),
        .s_bin       (s_bin),
        .e_bin       (e_bin)
    );

    assign lo_bin    = (s_bin > e_bin) ? e_bin : s_bin;
    assign hi_bin    = (s_bin > e_bin) ? s_bin : e_bin;
    assign span      = hi_bin - lo_bin;
    assign tot_wide  = {1'b0, total_reg} + {6'b0, span};
    assign tot_sat   = tot_wide[hzr_pkg::CNT_W] ? '1 : tot_wide[hzr_pkg::CNT_W-1:0];
    assign last_harm = (h_reg == end_h_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bph_reg     <= hzr_pkg::BINS_PER_HZ_RST;
            np_reg      <= hzr_pkg::NPTS_RST;
            busy_reg    <= 1'b0;
            pc_reg      <= hzr_pkg::STEP_EDGE_A;
            h_reg       <= '0;
            end_h_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    hzr_pkg::REG_BINS_PER_HZ:     bph_reg <= cfg_wr_data;
                    hzr_pkg::REG_SPECTRUM_POINTS: np_reg  <= cfg_wr_data[hzr_pkg::BIN_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_accept) begin
                busy_reg  <= 1'b1;
                h_reg     <= fh_adj;
                end_h_reg <= lh_adj;
                total_reg <= '0;
                if (s_axis_tuser) begin
                    base_a_reg <= in_sum;
                    base_b_reg <= in_sum;
                    off_reg    <= in_diff;
                end else begin
                    base_a_reg <= {in_lo, 1'b0};
                    base_b_reg <= {in_hi, 1'b0};
                    off_reg    <= '0;
                end
                pc_reg <= (fh_adj > lh_adj) ? hzr_pkg::STEP_EMPTY : hzr_pkg::STEP_EDGE_A;
            end else if (busy_reg) begin
                if (uop.load_f) begin
                    freq_reg <= f_sum[hzr_pkg::SCL_W-1:0];
                end
                if (uop.empty) begin
                    if (out_free) begin
                        m_start_reg <= '0;
                        m_end_reg   <= '0;
                        m_harm_reg  <= '0;
                        m_count_reg <= '0;
                        m_last_reg  <= 1'b1;
                        busy_reg    <= 1'b0;
                    end
                end else if (uop.emit) begin
                    if (out_free) begin
                        m_start_reg <= lo_bin;
                        m_end_reg   <= hi_bin;
                        m_harm_reg  <= h_reg;
                        m_count_reg <= tot_sat;
                        m_last_reg  <= last_harm;
                        total_reg   <= tot_sat;
                        if (last_harm) begin
                            busy_reg <= 1'b0;
                        end else begin
                            h_reg  <= h_reg + hzr_pkg::HARM_W'(1);
                            pc_reg <= hzr_pkg::STEP_EDGE_A;
                        end
                    end
                end else begin
                    pc_reg <= pc_reg + hzr_pkg::step_t'(1);
                end
            end
        end
    end

    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {3'b0, m_count_reg, m_harm_reg, m_end_reg, m_start_reg};

    // ranges come out ordered and inside the spectrum
    a_range_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_start_reg <= m_end_reg))
        else $error("bin range out of order");

    a_range_in_spectrum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_end_reg <= np_reg))
        else $error("bin range beyond spectrum");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_harm_reg == '0) |-> (m_last_reg && m_count_reg == '0
            && m_start_reg == '0 && m_end_reg == '0))
        else $error("empty result malformed");

    a_program_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (busy_reg && (pc_reg == hzr_pkg::STEP_EDGE_A
            || pc_reg == hzr_pkg::STEP_EMPTY)))
        else $error("sequencer entered at wrong step");

endmodule
